// ----- src/pai_pkg.sv -----
package pai_pkg;

  // Field widths
  localparam int POS_W    = 20;
  localparam int VEL_W    = 25;
  localparam int TGT_W    = 21;
  localparam int DT_W     = 16;
  localparam int SIZE_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Internal widths
  localparam int D_W      = 22;            // signed offset pos - target
  localparam int DMAG_W   = 21;            // offset magnitude
  localparam int SQ_W     = 43;            // sum of squares
  localparam int LEN_W    = 22;            // integer square root
  localparam int DEN_W    = 44;            // len * max(len, 0.5)
  localparam int Q_W      = 18;            // pull quotient, at most 2^17
  localparam int NUM_PRE  = 24 - Q_W;      // numerator bits preloaded into the remainder
  localparam int REM_W    = DEN_W + 1;
  localparam int SQ_STEPS = LEN_W;
  localparam int DIV_STEPS = Q_W;
  localparam int V1_W     = VEL_W + 1;
  localparam int DAMP_W   = 16;
  localparam int K_W      = DT_W + 7;      // frame_time * 100
  localparam int PM_W     = VEL_W + K_W;
  localparam int P_W      = 26;            // position sum before wrap
  localparam int WRAP_W   = SIZE_W + 8;

  // Constants
  localparam logic [DAMP_W-1:0] DAMP_Q16    = 16'd64881;  // 0.99
  localparam logic [6:0]        SPEED_SCALE = 7'd100;
  localparam logic [LEN_W-1:0]  HALF_Q8     = 22'd128;
  localparam logic [LEN_W-1:0]  ONE_Q8      = 22'd256;
  localparam logic [POS_W-1:0]  POS_MAX     = 20'hFFFFF;
  localparam logic [VEL_W-1:0]  VEL_POS_MAG = 25'd16777215;
  localparam logic [VEL_W-1:0]  VEL_NEG_MAG = 25'd16777216;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [SIZE_W-1:0]    SCREEN_WIDTH_RST  = 13'd800;
  localparam logic [SIZE_W-1:0]    SCREEN_HEIGHT_RST = 13'd450;

  // One particle in flight; index 0 is x, 1 is y
  typedef struct packed {
    logic [1:0][POS_W-1:0] pos;
    logic [1:0][VEL_W-1:0] vel;
    logic [1:0][D_W-1:0]   d;
    logic [DT_W-1:0]       dt;
  } pai_item_t;

  function automatic logic [DMAG_W-1:0] d_mag(input logic [D_W-1:0] d);
    logic [D_W-1:0] n;
    n = -d;
    return d[D_W-1] ? n[DMAG_W-1:0] : d[DMAG_W-1:0];
  endfunction

endpackage

// ----- src/pai_if.sv -----
interface pai_in_if;
  import pai_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         pos_x;
  logic [POS_W-1:0]         pos_y;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_y;
  logic signed [TGT_W-1:0]  target_x;
  logic signed [TGT_W-1:0]  target_y;
  logic [DT_W-1:0]          frame_time;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, target_x, target_y, frame_time,
                  input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, target_x, target_y, frame_time,
                output ready);
endinterface

interface pai_out_if;
  import pai_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         new_pos_x;
  logic [POS_W-1:0]         new_pos_y;
  logic signed [VEL_W-1:0]  new_vel_x;
  logic signed [VEL_W-1:0]  new_vel_y;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, output ready);
endinterface

interface pai_cfg_if;
  import pai_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [SIZE_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/pai_sqrt.sv -----
module pai_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  pai_pkg::pai_item_t        in_item,
  input  logic [pai_pkg::SQ_W-1:0]  in_sum,
  output logic                      out_valid,
  output pai_pkg::pai_item_t        out_item,
  output logic [pai_pkg::LEN_W-1:0] out_len
);
  import pai_pkg::*;

  localparam int N  = SQ_STEPS;
  localparam int RW = SQ_W + 1;

  logic [RW-1:0] x_c [N];
  logic [RW-1:0] r_c [N];
  logic [RW-1:0] bit_c [N];
  logic [RW-1:0] trial_c [N];
  logic [RW-1:0] x_nxt [N];
  logic [RW-1:0] r_nxt [N];
  pai_item_t     it_c [N];
  logic          v_c [N];

  logic [RW-1:0] x_r [N];
  logic [RW-1:0] r_r [N];
  pai_item_t     it_r [N];
  logic          v_r [N];

  // One result bit per stage, most significant first
  always_comb begin
    x_c[0]  = RW'(in_sum);
    r_c[0]  = '0;
    it_c[0] = in_item;
    v_c[0]  = in_valid;
    for (int k = 1; k < N; k++) begin
      x_c[k]  = x_r[k-1];
      r_c[k]  = r_r[k-1];
      it_c[k] = it_r[k-1];
      v_c[k]  = v_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      bit_c[k]   = RW'(1) << (2 * (N - 1 - k));
      trial_c[k] = r_c[k] + bit_c[k];
      if (x_c[k] >= trial_c[k]) begin
        x_nxt[k] = x_c[k] - trial_c[k];
        r_nxt[k] = (r_c[k] >> 1) + bit_c[k];
      end else begin
        x_nxt[k] = x_c[k];
        r_nxt[k] = r_c[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        x_r[k]  <= x_nxt[k];
        r_r[k]  <= r_nxt[k];
        it_r[k] <= it_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < N; k++) v_r[k] <= v_c[k];
    end
  end

  assign out_valid = v_r[N-1];
  assign out_item  = it_r[N-1];
  assign out_len   = r_r[N-1][LEN_W-1:0];

endmodule

// ----- src/pai_div.sv -----
module pai_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  pai_pkg::pai_item_t              in_item,
  input  logic [pai_pkg::DEN_W-1:0]       in_den,
  output logic                            out_valid,
  output pai_pkg::pai_item_t              out_item,
  output logic [1:0][pai_pkg::Q_W-1:0]    out_quo
);
  import pai_pkg::*;

  localparam int N = DIV_STEPS;

  logic [1:0][REM_W-1:0] rem_c [N];
  logic [1:0][REM_W-1:0] sh_c [N];
  logic [1:0][REM_W-1:0] rem_nxt [N];
  logic [1:0][Q_W-1:0]   q_c [N];
  logic [1:0][Q_W-1:0]   q_nxt [N];
  logic [DEN_W-1:0]      den_c [N];
  pai_item_t             it_c [N];
  logic                  v_c [N];

  logic [1:0][REM_W-1:0] rem_r [N];
  logic [1:0][Q_W-1:0]   q_r [N];
  logic [DEN_W-1:0]      den_r [N];
  pai_item_t             it_r [N];
  logic                  v_r [N];

  // Restoring division of |d| * 2^24 by den, one quotient bit per stage.
  // The low numerator bits are zero, so only a zero shifts in.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rem_c[0][a] = REM_W'({d_mag(in_item.d[a]), NUM_PRE'(0)});
      q_c[0][a]   = '0;
    end
    den_c[0] = in_den;
    it_c[0]  = in_item;
    v_c[0]   = in_valid;
    for (int k = 1; k < N; k++) begin
      rem_c[k] = rem_r[k-1];
      q_c[k]   = q_r[k-1];
      den_c[k] = den_r[k-1];
      it_c[k]  = it_r[k-1];
      v_c[k]   = v_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      for (int a = 0; a < 2; a++) begin
        sh_c[k][a] = {rem_c[k][a][REM_W-2:0], 1'b0};
        if (sh_c[k][a] >= REM_W'(den_c[k])) begin
          rem_nxt[k][a] = sh_c[k][a] - REM_W'(den_c[k]);
          q_nxt[k][a]   = {q_c[k][a][Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][a] = sh_c[k][a];
          q_nxt[k][a]   = {q_c[k][a][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        den_r[k] <= den_c[k];
        it_r[k]  <= it_c[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < N; k++) v_r[k] <= v_c[k];
    end
  end

  assign out_valid = v_r[N-1];
  assign out_item  = it_r[N-1];
  assign out_quo   = q_r[N-1];

endmodule

// ----- src/particle_attract_integrate_wrap.sv -----
// Particle update pipeline: attraction toward a point, damping, integration
// and screen wrap for one particle per transfer.
//
// Channels: in_chan takes a particle (position, velocity, attractor, frame
// time); out_chan returns the new position and velocity; cfg_chan writes the
// screen width (index 0) and height (index 1), always ready. Write the
// screen size only while no particle is in flight.
//
// Throughput: one particle per cycle while out_chan does not stall. The
// length is a 22-stage square root and the pull a 18-stage restoring
// divider, one bit per stage; every stage carries its own valid bit.
//
// Stall: the whole pipeline advances together. When out_chan holds a result
// that is not taken, every stage holds and in_chan.ready drops; bubbles
// still move so ready stays high while the last stage is empty.
// Reset: clears all valid bits and loads the screen size to 800 x 450.
module particle_attract_integrate_wrap (
  input  logic      clk,
  input  logic      rst_n,
  pai_in_if.sink    in_chan,
  pai_out_if.source out_chan,
  pai_cfg_if.sink   cfg_chan
);
  import pai_pkg::*;

  logic adv;

  // Configuration
  logic [SIZE_W-1:0] screen_width_r;
  logic [SIZE_W-1:0] screen_height_r;
  logic [1:0][WRAP_W-1:0] wrap_c;

  // Front stages
  pai_item_t              item0_nxt;
  pai_item_t              item0_r, item1_r, item2_r;
  logic [1:0][2*DMAG_W-1:0] sq_r;
  logic [SQ_W-1:0]        sum_r;
  logic                   v0_r, v1_r, v2_r;

  // Square root
  logic                   sq_valid;
  pai_item_t              sq_item;
  logic [LEN_W-1:0]       sq_len;
  logic [LEN_W-1:0]       len_fix_c, len_max_c;
  pai_item_t              item3_r;
  logic [DEN_W-1:0]       den_r;
  logic                   v3_r;

  // Divider
  logic                   dv_valid;
  pai_item_t              dv_item;
  logic [1:0][Q_W-1:0]    dv_quo;

  // Velocity and position tail
  logic signed [V1_W-1:0] f_c [2];
  logic signed [V1_W-1:0] v1_c [2];
  logic [V1_W:0]          rnd_c [2];
  logic [V1_W:0]          vlim_c [2];
  logic [VEL_W-1:0]       vmag_c [2];
  logic [PM_W:0]          prnd_c [2];
  logic [VEL_W-1:0]       st_c [2];
  logic signed [P_W-1:0]  p_c [2];
  logic signed [P_W-1:0]  pw_c [2];
  logic signed [P_W-1:0]  pf_c [2];

  pai_item_t              item4_r, item5_r, item6_r, item7_r;
  logic [1:0]             neg4_r, neg5_r, neg6_r, neg7_r;
  logic [V1_W-1:0]        v1mag4_r [2];
  logic [V1_W+DAMP_W-1:0] m5_r [2];
  logic [K_W-1:0]         k5_r, k6_r;
  logic [VEL_W-1:0]       v2_6_r [2], v2_7_r [2], v2_8_r [2], v2_9_r [2];
  logic [VEL_W-1:0]       vmag6_r [2];
  logic [PM_W-1:0]        pm7_r [2];
  logic signed [P_W-1:0]  p8_r [2], p9_r [2];
  logic                   v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;

  // Output register
  logic                   out_valid_r;
  logic [POS_W-1:0]       out_pos_r [2];
  logic [VEL_W-1:0]       out_vel_r [2];

  // Advance whenever the output register is empty or being taken
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_chan.data;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign wrap_c[0] = {screen_width_r, 8'd0};
  assign wrap_c[1] = {screen_height_r, 8'd0};

  // Stage 0: capture the particle and form the offsets from the attractor
  always_comb begin
    item0_nxt.pos[0] = in_chan.pos_x;
    item0_nxt.pos[1] = in_chan.pos_y;
    item0_nxt.vel[0] = in_chan.vel_x;
    item0_nxt.vel[1] = in_chan.vel_y;
    item0_nxt.dt     = in_chan.frame_time;
    item0_nxt.d[0]   = {2'b00, in_chan.pos_x} - {in_chan.target_x[TGT_W-1], in_chan.target_x};
    item0_nxt.d[1]   = {2'b00, in_chan.pos_y} - {in_chan.target_y[TGT_W-1], in_chan.target_y};
  end

  // Square root length; a zero length counts as one, the second factor
  // is floored at one half
  always_comb begin
    len_fix_c = (sq_len == '0) ? ONE_Q8 : sq_len;
    len_max_c = (len_fix_c > HALF_Q8) ? len_fix_c : HALF_Q8;
  end

  // Pull, velocity update, damping, step and wrap
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      f_c[a]  = dv_item.d[a][D_W-1] ? -$signed(V1_W'(dv_quo[a])) : $signed(V1_W'(dv_quo[a]));
      v1_c[a] = $signed({dv_item.vel[a][VEL_W-1], dv_item.vel[a]}) - f_c[a];

      // round half away from zero, then clamp the magnitude per sign
      rnd_c[a]  = (V1_W+1)'(m5_r[a][V1_W+DAMP_W-1:DAMP_W]) + (V1_W+1)'(m5_r[a][DAMP_W-1]);
      vlim_c[a] = neg5_r[a] ? (V1_W+1)'(VEL_NEG_MAG) : (V1_W+1)'(VEL_POS_MAG);
      vmag_c[a] = (rnd_c[a] > vlim_c[a]) ? vlim_c[a][VEL_W-1:0] : rnd_c[a][VEL_W-1:0];

      prnd_c[a] = (PM_W+1)'(pm7_r[a]) + (PM_W+1)'(1 << 23);
      st_c[a]   = prnd_c[a][PM_W:24];
      p_c[a]    = neg7_r[a] ? $signed(P_W'(item7_r.pos[a])) - $signed(P_W'(st_c[a]))
                            : $signed(P_W'(item7_r.pos[a])) + $signed(P_W'(st_c[a]));

      pw_c[a] = (p8_r[a] < 0) ? p8_r[a] + $signed(P_W'(wrap_c[a])) : p8_r[a];

      pf_c[a] = (p9_r[a] >= $signed(P_W'(wrap_c[a]))) ? p9_r[a] - $signed(P_W'(wrap_c[a]))
                                                       : p9_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item0_r <= item0_nxt;
      for (int a = 0; a < 2; a++) begin
        sq_r[a] <= (2*DMAG_W)'(d_mag(item0_r.d[a])) * (2*DMAG_W)'(d_mag(item0_r.d[a]));
      end
      item1_r <= item0_r;
      sum_r   <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]);
      item2_r <= item1_r;

      den_r   <= DEN_W'(len_fix_c) * DEN_W'(len_max_c);
      item3_r <= sq_item;

      item4_r <= dv_item;
      for (int a = 0; a < 2; a++) begin
        neg4_r[a]   <= v1_c[a][V1_W-1];
        v1mag4_r[a] <= v1_c[a][V1_W-1] ? V1_W'(-v1_c[a]) : V1_W'(v1_c[a]);
      end

      item5_r <= item4_r;
      neg5_r  <= neg4_r;
      k5_r    <= K_W'(item4_r.dt) * K_W'(SPEED_SCALE);
      for (int a = 0; a < 2; a++) begin
        m5_r[a] <= (V1_W+DAMP_W)'(v1mag4_r[a]) * (V1_W+DAMP_W)'(DAMP_Q16);
      end

      item6_r <= item5_r;
      neg6_r  <= neg5_r;
      k6_r    <= k5_r;
      for (int a = 0; a < 2; a++) begin
        vmag6_r[a] <= vmag_c[a];
        v2_6_r[a]  <= neg5_r[a] ? -vmag_c[a] : vmag_c[a];
      end

      item7_r <= item6_r;
      neg7_r  <= neg6_r;
      for (int a = 0; a < 2; a++) begin
        pm7_r[a] <= PM_W'(vmag6_r[a]) * PM_W'(k6_r);
        v2_7_r[a] <= v2_6_r[a];
      end

      for (int a = 0; a < 2; a++) begin
        p8_r[a]   <= p_c[a];
        v2_8_r[a] <= v2_7_r[a];
        p9_r[a]   <= pw_c[a];
        v2_9_r[a] <= v2_8_r[a];
      end

      // final wrap and clamp into the output register
      for (int a = 0; a < 2; a++) begin
        if (pf_c[a] < 0) begin
          out_pos_r[a] <= '0;
        end else if (pf_c[a] > $signed(P_W'(POS_MAX))) begin
          out_pos_r[a] <= POS_MAX;
        end else begin
          out_pos_r[a] <= pf_c[a][POS_W-1:0];
        end
        out_vel_r[a] <= v2_9_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_chan.valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= sq_valid;
      v4_r        <= dv_valid;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      out_valid_r <= v9_r;
    end
  end

  pai_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v2_r),
    .in_item   (item2_r),
    .in_sum    (sum_r),
    .out_valid (sq_valid),
    .out_item  (sq_item),
    .out_len   (sq_len)
  );

  pai_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v3_r),
    .in_item   (item3_r),
    .in_den    (den_r),
    .out_valid (dv_valid),
    .out_item  (dv_item),
    .out_quo   (dv_quo)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.new_pos_x = out_pos_r[0];
  assign out_chan.new_pos_y = out_pos_r[1];
  assign out_chan.new_vel_x = out_vel_r[0];
  assign out_chan.new_vel_y = out_vel_r[1];

endmodule

// ----- src/pai_checker.sv -----
module pai_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pai_pkg::POS_W-1:0]         out_pos_x,
  input logic [pai_pkg::POS_W-1:0]         out_pos_y,
  input logic signed [pai_pkg::VEL_W-1:0]  out_vel_x,
  input logic signed [pai_pkg::VEL_W-1:0]  out_vel_y
);
  import pai_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_pos_y)
                                && $stable(out_vel_x) && $stable(out_vel_y))
    else $error("result payload changed while stalled");

  // a free receiver never backs up into the input
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  // a waiting particle is held back only behind a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // reset empties the pipeline
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind particle_attract_integrate_wrap pai_checker u_pai_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_pos_x (out_chan.new_pos_x),
  .out_pos_y (out_chan.new_pos_y),
  .out_vel_x (out_chan.new_vel_x),
  .out_vel_y (out_chan.new_vel_y)
);

// ----- bench/tb_particle_attract_integrate_wrap.sv -----
module tb_particle_attract_integrate_wrap;
  import pai_pkg::*;

  // Spare register indexes: writes there must leave the screen size alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int PIPE_DRAIN  = 60;      // a bit more than the pipeline latency
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 72;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [POS_W-1:0]        pos_x, pos_y;
    logic signed [VEL_W-1:0] vel_x, vel_y;
    logic signed [TGT_W-1:0] target_x, target_y;
    logic [DT_W-1:0]         frame_time;
  } particle_t;

  typedef struct {
    logic [POS_W-1:0]        pos_x, pos_y;
    logic signed [VEL_W-1:0] vel_x, vel_y;
  } motion_t;

  typedef struct {
    particle_t p;
    bit        typed;   // result given by hand instead of the predictor
    motion_t   m;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;

  pai_in_if  in_chan ();
  pai_out_if out_chan ();
  pai_cfg_if cfg_chan ();

  particle_attract_integrate_wrap DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always #6 clk = ~clk;

  // Screen size as the block should hold it
  logic [SIZE_W-1:0] width_q, height_q;
  motion_t           motion_q[$];
  int                mismatches;
  int                cycles;

  // ---------------------------------------------------------------------------
  // Predictor: exact integer version of the attract / damp / integrate / wrap
  // ---------------------------------------------------------------------------
  function automatic longint unsigned abs_of(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // |a| * k / 2^sh rounded half away from zero, sign of a kept
  function automatic longint round_scale(longint a, longint unsigned k, int sh);
    longint unsigned m;
    m = abs_of(a) * k;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return signed_of(m, a < 0);
  endfunction

  function automatic longint pulled_velocity(longint vel, longint d, longint unsigned den);
    longint unsigned pull;
    longint v;
    pull = (abs_of(d) << 24) / den;
    v = round_scale(vel - signed_of(pull, d < 0), 64'd64881, 16);
    if (v > 16777215) v = 16777215;
    if (v < -16777216) v = -16777216;
    return v;
  endfunction

  function automatic longint wrapped_position(longint pos, longint v2, longint unsigned dt,
                                              longint unsigned size);
    longint p, w;
    w = longint'(size << 8);
    p = pos + round_scale(v2, 64'd100 * dt, 24);
    if (p < 0) p += w;
    if (p >= w) p -= w;
    if (p < 0) p = 0;
    if (p > 1048575) p = 1048575;
    return p;
  endfunction

  function automatic motion_t particle_motion(particle_t p, logic [SIZE_W-1:0] w,
                                              logic [SIZE_W-1:0] h);
    longint dx, dy, vx, vy;
    longint unsigned len, den;
    motion_t m;
    dx = longint'(p.pos_x) - longint'(p.target_x);
    dy = longint'(p.pos_y) - longint'(p.target_y);
    len = root_floor(abs_of(dx) * abs_of(dx) + abs_of(dy) * abs_of(dy));
    if (len == 0) len = 256;
    den = len * (len > 128 ? len : 64'd128);
    vx = pulled_velocity(longint'(p.vel_x), dx, den);
    vy = pulled_velocity(longint'(p.vel_y), dy, den);
    m.vel_x = vx[VEL_W-1:0];
    m.vel_y = vy[VEL_W-1:0];
    m.pos_x = POS_W'(wrapped_position(longint'(p.pos_x), vx, p.frame_time, w));
    m.pos_y = POS_W'(wrapped_position(longint'(p.pos_y), vy, p.frame_time, h));
    return m;
  endfunction

  function automatic particle_t particle(longint px, longint py, longint vx, longint vy,
                                        longint tx, longint ty, longint dt);
    particle_t p;
    p.pos_x = px[POS_W-1:0];
    p.pos_y = py[POS_W-1:0];
    p.vel_x = vx[VEL_W-1:0];
    p.vel_y = vy[VEL_W-1:0];
    p.target_x = tx[TGT_W-1:0];
    p.target_y = ty[TGT_W-1:0];
    p.frame_time = dt[DT_W-1:0];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sampling: capture handshakes mid-cycle, act on them at the next rising edge
  // so nothing depends on event order inside the edge's time step
  // ---------------------------------------------------------------------------
  logic    in_ready_s, cfg_ready_s, out_fire_s;
  motion_t out_s;

  always @(negedge clk) begin
    in_ready_s  = in_chan.ready;
    cfg_ready_s = cfg_chan.ready;
    out_fire_s  = out_chan.valid && out_chan.ready;
    out_s.pos_x = out_chan.new_pos_x;
    out_s.pos_y = out_chan.new_pos_y;
    out_s.vel_x = out_chan.new_vel_x;
    out_s.vel_y = out_chan.new_vel_y;
  end

  // Compare each result transfer with the oldest pending expectation
  always @(posedge clk) begin
    motion_t e;
    if (rst_n && out_fire_s) begin
      if (motion_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: pos %h,%h vel %h,%h",
                   out_s.pos_x, out_s.pos_y, out_s.vel_x, out_s.vel_y);
      end else begin
        e = motion_q.pop_front();
        if (e.pos_x !== out_s.pos_x || e.pos_y !== out_s.pos_y ||
            e.vel_x !== out_s.vel_x || e.vel_y !== out_s.vel_y) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: exp pos %h,%h vel %h,%h  got pos %h,%h vel %h,%h",
                     e.pos_x, e.pos_y, e.vel_x, e.vel_y,
                     out_s.pos_x, out_s.pos_y, out_s.vel_x, out_s.vel_y);
        end
      end
    end
  end

  // Receiver stalls: a rotating 16-bit pattern, reloaded as stall_cnt comes round;
  // some reloads are all ones so long stretches run stall-free
  logic [15:0] stall_pat;
  int          stall_cnt;

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_pat <= 16'hFFFF;
      stall_cnt <= 0;
      out_chan.ready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63)
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      else
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
      out_chan.ready <= stall_pat[15];
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left;

  // Hold one particle on the input until it transfers, then queue its result.
  // Between bursts drop valid for a random gap.
  task automatic send_particle(particle_t p, bit typed, motion_t m);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_chan.valid      <= 1'b1;
    in_chan.pos_x      <= p.pos_x;
    in_chan.pos_y      <= p.pos_y;
    in_chan.vel_x      <= p.vel_x;
    in_chan.vel_y      <= p.vel_y;
    in_chan.target_x   <= p.target_x;
    in_chan.target_y   <= p.target_y;
    in_chan.frame_time <= p.frame_time;
    @(posedge clk);
    while (!in_ready_s) @(posedge clk);
    motion_q.push_back(typed ? m : particle_motion(p, width_q, height_q));
    burst_left--;
  endtask

  // Hold the input until every pending result has come out, then let the
  // pipeline drain before touching the screen size
  task automatic drain_pipeline();
    in_chan.valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Leave valid high after the transfer; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_ready_s) @(posedge clk);
    if (idx == CFG_SCREEN_WIDTH) width_q = val;
    else if (idx == CFG_SCREEN_HEIGHT) height_q = val;
  endtask

  // Mostly plausible particles on screen near the attractor; the rest is noise
  function automatic particle_t random_particle();
    particle_t p;
    longint wx, hy, px, py;
    if ($urandom_range(0, 3) == 0) begin
      p.pos_x = 20'($urandom);
      p.pos_y = 20'($urandom);
      p.vel_x = 25'($urandom);
      p.vel_y = 25'($urandom);
      p.target_x = 21'($urandom);
      p.target_y = 21'($urandom);
      p.frame_time = 16'($urandom);
      return p;
    end
    wx = (width_q == 0) ? 64'd4096 : longint'(width_q);
    hy = (height_q == 0) ? 64'd4096 : longint'(height_q);
    px = $urandom_range(0, 32'(wx * 256 - 1));
    py = $urandom_range(0, 32'(hy * 256 - 1));
    return particle(px, py,
                    longint'($urandom_range(0, 524288)) - 262144,
                    longint'($urandom_range(0, 524288)) - 262144,
                    px + longint'($urandom_range(0, 65536)) - 32768,
                    py + longint'($urandom_range(0, 65536)) - 32768,
                    $urandom_range(0, 2200));
  endfunction

  vector_t         vectors[$];
  logic [SIZE_W-1:0] size_plan[6][2] = '{'{13'd800, 13'd450}, '{13'd1, 13'd1},
                                         '{13'd4096, 13'd4096}, '{13'd0, 13'd0},
                                         '{13'd8191, 13'd8191}, '{13'd640, 13'd4095}};

  initial begin
    motion_t none;
    motion_t same;
    none = '{default: '0};
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    width_q = SCREEN_WIDTH_RST;
    height_q = SCREEN_HEIGHT_RST;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.pos_x <= '0;
    in_chan.pos_y <= '0;
    in_chan.vel_x <= '0;
    in_chan.vel_y <= '0;
    in_chan.target_x <= '0;
    in_chan.target_y <= '0;
    in_chan.frame_time <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= CFG_SCREEN_WIDTH;
    cfg_chan.data <= '0;

    // Directed table, run with the reset screen size. A particle resting on
    // the attractor feels no pull and does not move, so its result is known.
    same = '{pos_x: 20'd1000, pos_y: 20'd2000, vel_x: '0, vel_y: '0};
    vectors.push_back('{particle(1000, 2000, 0, 0, 1000, 2000, 1092), 1'b1, same});
    vectors.push_back('{particle(1000, 2000, 0, 0, 1000, 2000, 65535), 1'b1, same});
    vectors.push_back('{particle(0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    // zero length with motion, short length, exact half pixel
    vectors.push_back('{particle(5000, 6000, 65536, -65536, 5000, 6000, 1092), 1'b0, none});
    vectors.push_back('{particle(5000, 6000, 0, 0, 4950, 6020, 1092), 1'b0, none});
    vectors.push_back('{particle(5000, 6000, 0, 0, 4872, 6000, 1092), 1'b0, none});
    vectors.push_back('{particle(5000, 6000, 0, 0, 5001, 6000, 65535), 1'b0, none});
    // field extremes
    vectors.push_back('{particle(1048575, 1048575, 16777215, 16777215,
                                 -1048576, -1048576, 65535), 1'b0, none});
    vectors.push_back('{particle(0, 0, -16777216, -16777216,
                                 1048575, 1048575, 65535), 1'b0, none});
    vectors.push_back('{particle(1048575, 0, 16777215, -16777216,
                                 1048575, 0, 0), 1'b0, none});
    vectors.push_back('{particle(0, 1048575, -16777216, 16777215, 0, 1048575, 65535),
                        1'b0, none});
    // wrap below zero and past the edge, and far outside the screen
    vectors.push_back('{particle(100, 100, -4000000, -4000000, 100, 100, 65535), 1'b0, none});
    vectors.push_back('{particle(204700, 115100, 4000000, 4000000, 204700, 115100, 65535),
                        1'b0, none});
    vectors.push_back('{particle(900000, 700000, 1000, -1000, 800000, 600000, 1092),
                        1'b0, none});
    vectors.push_back('{particle(300, 200, 0, 0, 100000, -50000, 4000), 1'b0, none});
    vectors.push_back('{particle(51200, 51200, 300000, -300000, 51300, 51100, 2184),
                        1'b0, none});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) send_particle(vectors[i].p, vectors[i].typed, vectors[i].m);

    // Random phases, each under its own screen size; spare indexes get
    // junk writes that must change nothing
    foreach (size_plan[ph]) begin
      drain_pipeline();
      write_reg(CFG_SCREEN_WIDTH, size_plan[ph][0]);
      write_reg(CFG_SPARE_2, 13'($urandom));
      write_reg(CFG_SCREEN_HEIGHT, size_plan[ph][1]);
      write_reg(CFG_SPARE_3, 13'($urandom));
      cfg_chan.valid <= 1'b0;
      repeat (PHASE_ITEMS) send_particle(random_particle(), 1'b0, none);
    end

    in_chan.valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
